// File: rtl/stable_priority_queue_defines.svh
// Assertion helpers for the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Clocked assertion, disabled while in reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned ID_WIDTH       = 16;
  localparam int unsigned PRIO_WIDTH     = 8;
  localparam int unsigned CNT_WIDTH      = $clog2(DEPTH + 1);
  localparam int unsigned OCC_WIDTH      = 5;
  localparam int unsigned STATUS_WIDTH   = 2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [ID_WIDTH-1:0]   id;
    logic [PRIO_WIDTH-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
`default_nettype none

module spq_cell (
  input  wire logic              clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic              occ_i,
  input  wire spq_pkg::entry_t   left_i,
  input  wire logic              left_gt_i,
  input  wire spq_pkg::entry_t   right_i,
  output      spq_pkg::entry_t   entry_o,
  output      logic              gt_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // gt: this slot lies at or past the insert position
  assign gt_o    = !occ_i || (entry_q.prio > ctrl_i.ent.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && gt_o) begin
      entry_d = left_gt_i ? left_i : ctrl_i.ent;
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// File: rtl/stable_priority_queue.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// The result is registered in the output register at the input transfer.
// Throughput: one insert or remove per cycle unless the output stalls; every cell compares in parallel.
// Output register decouples sides; input is taken while the result drains.
// Reset (async, active low) empties the queue and the output register.
`default_nettype none
`include "stable_priority_queue_defines.svh"

module stable_priority_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic                           operation_i,
  input  wire logic [spq_pkg::ID_WIDTH-1:0]   item_id_i,
  input  wire logic [spq_pkg::PRIO_WIDTH-1:0] item_priority_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [spq_pkg::ID_WIDTH-1:0]   out_id_o,
  output      logic [spq_pkg::PRIO_WIDTH-1:0] out_priority_o,
  output      logic [spq_pkg::STATUS_WIDTH-1:0] status_o,
  output      logic [spq_pkg::OCC_WIDTH-1:0]  occupancy_o
);

  localparam int unsigned D = spq_pkg::DEPTH;

  logic [spq_pkg::CNT_WIDTH-1:0] count_q, count_d;
  logic                          out_valid_q;
  spq_pkg::entry_t               out_ent_q, out_ent_d;
  logic [spq_pkg::STATUS_WIDTH-1:0] status_q, status_d;

  logic                take;
  logic                rem_empty;
  logic                is_full, is_empty;
  spq_pkg::cell_ctrl_t ctrl;
  logic [D-1:0]        occ;
  logic [D-1:0]        gt;
  spq_pkg::entry_t     cell_ent [D];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign is_full    = (count_q == spq_pkg::CNT_WIDTH'(D));
  assign is_empty   = (count_q == '0);
  assign rem_empty  = take && (operation_i == spq_pkg::OP_REMOVE) && is_empty;

  always_comb begin
    for (int k = 0; k < D; k++) begin
      occ[k] = (spq_pkg::CNT_WIDTH'(k) < count_q);
    end
  end

  always_comb begin
    ctrl.ins      = take && (operation_i == spq_pkg::OP_INSERT) && !is_full;
    ctrl.rem      = take && (operation_i == spq_pkg::OP_REMOVE) && !is_empty;
    ctrl.ent.id   = item_id_i;
    ctrl.ent.prio = item_priority_i;
  end

  for (genvar k = 0; k < D; k++) begin : g_cell
    spq_pkg::entry_t left_ent, right_ent;
    logic            left_gt;
    if (k == 0) begin : g_first
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = cell_ent[k-1];
      assign left_gt  = gt[k-1];
    end
    if (k == D - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[k+1];
    end
    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ[k]),
      .left_i    (left_ent),
      .left_gt_i (left_gt),
      .right_i   (right_ent),
      .entry_o   (cell_ent[k]),
      .gt_o      (gt[k])
    );
  end

  always_comb begin
    count_d   = count_q;
    out_ent_d = '0;
    status_d  = spq_pkg::ST_OK;
    if (ctrl.ins) begin
      count_d = count_q + spq_pkg::CNT_WIDTH'(1);
    end else if (ctrl.rem) begin
      count_d   = count_q - spq_pkg::CNT_WIDTH'(1);
      out_ent_d = cell_ent[0];
    end
    if (operation_i == spq_pkg::OP_INSERT) begin
      if (is_full) status_d = spq_pkg::ST_FULL;
    end else begin
      if (is_empty) status_d = spq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_ent_q <= out_ent_d;
      status_q  <= status_d;
    end
  end

  logic [spq_pkg::CNT_WIDTH-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (take) occ_q <= count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_id_o       = out_ent_q.id;
  assign out_priority_o = out_ent_q.prio;
  assign status_o       = status_q;
  assign occupancy_o    = spq_pkg::OCC_WIDTH'(occ_q);

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_q <= spq_pkg::CNT_WIDTH'(D), "count above depth")
  `SPQ_ASSERT(a_ins_grows, ctrl.ins |=> count_q == $past(count_q) + spq_pkg::CNT_WIDTH'(1), "insert lost")
  `SPQ_ASSERT(a_rem_head, ctrl.rem |=> out_id_o == $past(cell_ent[0].id), "wrong head popped")
  `SPQ_ASSERT(a_empty_zero, rem_empty |=> status_o == spq_pkg::ST_EMPTY && out_id_o == '0, "empty remove")

endmodule

`default_nettype wire

// File: tb/tb_stable_priority_queue.sv
`default_nettype none

module tb_stable_priority_queue;

  localparam int unsigned RANDOM_ITEMS = 625;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned NUM_ROWS     = 25;

  typedef struct packed {
    logic [spq_pkg::ID_WIDTH-1:0]     id;
    logic [spq_pkg::PRIO_WIDTH-1:0]   prio;
    logic [spq_pkg::STATUS_WIDTH-1:0] status;
    logic [spq_pkg::OCC_WIDTH-1:0]    occ;
  } pq_result_t;

  typedef struct packed {
    logic                           op;
    logic [spq_pkg::ID_WIDTH-1:0]   id;
    logic [spq_pkg::PRIO_WIDTH-1:0] prio;
    logic                           typed;
    pq_result_t                     res;
  } stim_row_t;

  // typed rows carry a hand-computed result; others use the shadow queue
  localparam stim_row_t PLAN [NUM_ROWS] = '{
    '{spq_pkg::OP_REMOVE, 16'h0000, 8'h00, 1'b1, '{16'h0000, 8'h00, spq_pkg::ST_EMPTY, 5'd0}},
    '{spq_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{16'h0000, 8'h00, spq_pkg::ST_OK,    5'd1}},
    '{spq_pkg::OP_REMOVE, 16'h1234, 8'h12, 1'b1, '{16'hFFFF, 8'hFF, spq_pkg::ST_OK,    5'd0}},
    '{spq_pkg::OP_INSERT, 16'h0000, 8'h00, 1'b1, '{16'h0000, 8'h00, spq_pkg::ST_OK,    5'd1}},
    '{spq_pkg::OP_REMOVE, 16'hA5A5, 8'h5A, 1'b1, '{16'h0000, 8'h00, spq_pkg::ST_OK,    5'd0}},
    '{spq_pkg::OP_INSERT, 16'h0001, 8'h80, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h0002, 8'h10, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h0003, 8'h80, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h0004, 8'hFF, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h0005, 8'h00, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h0006, 8'h10, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h0007, 8'h80, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h8000, 8'h7F, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h5555, 8'h01, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'hAAAA, 8'hFE, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h00FF, 8'h80, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'hFF00, 8'h00, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h0F0F, 8'h55, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'hF0F0, 8'hAA, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'h7FFF, 8'h10, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'hFFFE, 8'hFF, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 16'hBEEF, 8'h00, 1'b1, '{16'h0000, 8'h00, spq_pkg::ST_FULL,  5'd16}},
    '{spq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 16'h3C3C, 8'hC3, 1'b0, '0}
  };

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic                             operation_i;
  logic [spq_pkg::ID_WIDTH-1:0]     item_id_i;
  logic [spq_pkg::PRIO_WIDTH-1:0]   item_priority_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [spq_pkg::ID_WIDTH-1:0]     out_id_o;
  logic [spq_pkg::PRIO_WIDTH-1:0]   out_priority_o;
  logic [spq_pkg::STATUS_WIDTH-1:0] status_o;
  logic [spq_pkg::OCC_WIDTH-1:0]    occupancy_o;

  logic [spq_pkg::ID_WIDTH-1:0]   shadow_ids   [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_WIDTH-1:0] shadow_prios [spq_pkg::DEPTH];
  int unsigned                    shadow_count;

  pq_result_t  due_results [$];
  int unsigned fail_count;
  int unsigned stall_cycles;
  bit          steady;

  stable_priority_queue u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .item_id_i       (item_id_i),
    .item_priority_i (item_priority_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_id_o        (out_id_o),
    .out_priority_o  (out_priority_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // sorted shadow of the queue; stable for equal priorities
  function automatic pq_result_t sorted_queue_step(input logic op,
                                                  input logic [spq_pkg::ID_WIDTH-1:0] id,
                                                  input logic [spq_pkg::PRIO_WIDTH-1:0] prio);
    pq_result_t  r;
    int unsigned pos;
    r = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (shadow_count >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prios[pos] <= prio) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_ids[k]   = shadow_ids[k-1];
          shadow_prios[k] = shadow_prios[k-1];
        end
        shadow_ids[pos]   = id;
        shadow_prios[pos] = prio;
        shadow_count++;
        r.status = spq_pkg::ST_OK;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.id   = shadow_ids[0];
        r.prio = shadow_prios[0];
        for (int k = 1; k < shadow_count; k++) begin
          shadow_ids[k-1]   = shadow_ids[k];
          shadow_prios[k-1] = shadow_prios[k];
        end
        shadow_count--;
        r.status = spq_pkg::ST_OK;
      end
    end
    r.occ = spq_pkg::OCC_WIDTH'(shadow_count);
    return r;
  endfunction

  // starts and ends at a falling edge; valid held until the transfer
  task automatic drive_item(input logic op, input logic [spq_pkg::ID_WIDTH-1:0] id,
                            input logic [spq_pkg::PRIO_WIDTH-1:0] prio, input logic typed,
                            input pq_result_t typed_res);
    pq_result_t r;
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    item_id_i       <= id;
    item_priority_i <= prio;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = sorted_queue_step(op, id, prio);
    due_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= steady || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    pq_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected transfer id=%h prio=%h status=%0d occ=%0d",
                 $time, out_id_o, out_priority_o, status_o, occupancy_o);
        fail_count++;
      end else begin
        e = due_results.pop_front();
        if (out_id_o !== e.id) begin
          $display("%0t: out_id expected %h actual %h", $time, e.id, out_id_o);
          fail_count++;
        end
        if (out_priority_o !== e.prio) begin
          $display("%0t: out_priority expected %h actual %h", $time, e.prio, out_priority_o);
          fail_count++;
        end
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          fail_count++;
        end
        if (occupancy_o !== e.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occupancy_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, stall_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic                           op;
    logic [spq_pkg::ID_WIDTH-1:0]   id;
    logic [spq_pkg::PRIO_WIDTH-1:0] prio;
    int unsigned                    ins_pct;
    int unsigned                    guard;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = spq_pkg::OP_INSERT;
    item_id_i       = '0;
    item_priority_i = '0;
    out_ready_i     = 1'b0;
    shadow_count    = 0;
    fail_count      = 0;
    stall_cycles    = 0;
    steady          = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < NUM_ROWS; n++) begin
      drive_item(PLAN[n].op, PLAN[n].id, PLAN[n].prio, PLAN[n].typed, PLAN[n].res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 200 && n < 330);
      if (n == 400) begin
        in_valid_i <= 1'b0;
        while (due_results.size() != 0) @(negedge clk_i);
      end
      // phases: fill, drain, mixed
      case ((n / 50) % 3)
        0:       ins_pct = 80;
        1:       ins_pct = 25;
        default: ins_pct = 50;
      endcase
      op   = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
      id   = spq_pkg::ID_WIDTH'($urandom_range(0, (1 << spq_pkg::ID_WIDTH) - 1));
      // narrow range half the time to force ties
      prio = $urandom_range(0, 1)
           ? spq_pkg::PRIO_WIDTH'($urandom_range(0, 3))
           : spq_pkg::PRIO_WIDTH'($urandom_range(0, (1 << spq_pkg::PRIO_WIDTH) - 1));
      drive_item(op, id, prio, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    guard = 0;
    while (due_results.size() != 0 && guard < STALL_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      fail_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: stable_priority_queue.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
